[sv/ppcd_pkg.sv]
// Shared command codes and arithmetic-unit operation codes for the sample pool.
`default_nettype none

package ppcd_pkg;

    // Command codes carried on the cmd port
    localparam logic [2:0] CMD_ADD         = 3'd0;
    localparam logic [2:0] CMD_REMOVE      = 3'd1;
    localparam logic [2:0] CMD_READ        = 3'd2;
    localparam logic [2:0] CMD_CLEAR       = 3'd3;
    localparam logic [2:0] CMD_RESET_SCALE = 3'd4;

    // Operation select of the shared add/subtract/compare unit
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // Register indexes of the configuration port
    localparam logic REG_DOUBLING_ENABLE = 1'b0;

endpackage : ppcd_pkg

`default_nettype wire

[sv/particle_pool_contract_double.sv]
// Top level of the sample pool with contraction and doubling: sequencer and config port.
//
// Usage:
//   Command channel: drive cmd, entry_data, slot_index and random_slot and raise
//   start; the transaction is taken at the rising edge where start is high and
//   busy is low. busy stays high until the result has been shown.
//   Result channel: done is high for exactly one cycle with all result ports
//   valid; the receiver must take it in that cycle, there is no back-pressure.
//   Config port: APB-style, one register (doubling_enable, byte address 0),
//   pready tied high, writes land on the access cycle.
// Sequence:
//   Add, read, clear, reset-scaling and unused codes: decode, then done; a new
//   transaction is taken only once the block is back in idle.
//   Remove: decode, decrement and hole fill (slot below count), doubling check,
//   done; a remove on an empty pool goes from decode straight to done.
//   Each doubling round copies the pool's c entries, one read and one write per entry.
// Reset: count, counters and flags clear, doubling_enable returns to 1; the
//   entry store is not cleared and needs no clearing pass.
`default_nettype none

module particle_pool_contract_double #(
    parameter int LEVELS      = 10,
    parameter int ENTRY_WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [63:0] entry_data,
    input  wire logic [9:0]  slot_index,
    input  wire logic [10:0] random_slot,
    // result channel
    output logic             done,
    output logic [10:0]      placed_slot,
    output logic [63:0]      read_data,
    output logic             read_valid,
    output logic [10:0]      entry_count,
    output logic [15:0]      contraction_total,
    output logic [7:0]       doubling_total,
    output logic             contraction_warning,
    output logic             doubling_armed,
    output logic             empty_error,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ppcd_pkg::*;

    // Derived sizes
    localparam int CAP   = 1 << LEVELS;
    localparam int CW    = LEVELS + 1;              // count width, holds CAP itself
    localparam int AW    = (CW > 11) ? CW : 11;     // arithmetic width, covers ports
    localparam int SLACK = (LEVELS > 5) ? (1 << (LEVELS - 5)) : 1;
    localparam logic [AW-1:0] CAP_A    = AW'(CAP);
    localparam logic [AW-1:0] CUTOFF_A = AW'((3 * CAP) / 4);
    localparam logic [AW-1:0] LIMIT_A  = AW'(CAP / 2 - SLACK);
    localparam logic [AW-1:0] ONE_A    = AW'(1);
    localparam logic [15:0]   WARN_TH  = 16'(CAP / 100);   // 100*x > CAP  <=>  x > CAP/100

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_REM_DEC = 4'd2;
    localparam logic [3:0] S_REM_WR  = 4'd3;
    localparam logic [3:0] S_DBL_CHK = 4'd4;
    localparam logic [3:0] S_DBL_RD  = 4'd5;
    localparam logic [3:0] S_DBL_WR  = 4'd6;
    localparam logic [3:0] S_DBL_END = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [ENTRY_WIDTH-1:0] data_reg, data_next;
    logic [9:0]             slot_reg, slot_next;
    logic [10:0]            rslot_reg, rslot_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [15:0]            contr_reg, contr_next;
    logic [7:0]             dbl_reg, dbl_next;
    logic                   warn_reg, warn_next;
    logic                   armed_reg, armed_next;
    logic                   en_reg, en_next;
    logic [AW-1:0]          placed_reg, placed_next;
    logic                   rvalid_reg, rvalid_next;
    logic                   err_reg, err_next;
    logic [LEVELS-1:0]      base_reg, base_next;   // pool size at the start of a round
    logic [LEVELS-1:0]      k_reg, k_next;         // copy source index
    logic [LEVELS-1:0]      dst_reg, dst_next;     // copy destination index

    logic                   accept;
    logic                   cfg_wr;
    logic [AW-1:0]          count_a, slot_a, rslot_a;
    logic [15:0]            contr_inc;

    // shared arithmetic unit
    logic                   alu_op;
    logic [AW-1:0]          alu_a, alu_b, alu_sum;
    logic                   alu_lt;

    // entry store ports
    logic                   mem_wr_en, mem_rd_en;
    logic [LEVELS-1:0]      mem_wr_addr, mem_rd_addr;
    logic [ENTRY_WIDTH-1:0] mem_wr_data, mem_rd_data;

    assign accept    = start && !busy;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign count_a   = AW'(count_reg);
    assign slot_a    = AW'(slot_reg);
    assign rslot_a   = AW'(rslot_reg);
    assign contr_inc = (contr_reg == 16'hFFFF) ? contr_reg : (contr_reg + 16'd1);

    ppcd_alu #(
        .AW (AW)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    ppcd_mem #(
        .ADDR_W (LEVELS),
        .DATA_W (ENTRY_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Operand select of the shared unit, per sequencer step
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_DECODE:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    alu_a = count_a;        // count + 1 for the arming test
                    alu_b = ONE_A;
                end
                else
                begin
                    alu_a = slot_a;         // slot < count for remove and read
                    alu_b = count_a;
                end
            end
            S_REM_DEC:
            begin
                alu_op = ALU_SUB;
                alu_a  = count_a;
                alu_b  = ONE_A;
            end
            S_DBL_CHK:
            begin
                alu_a = count_a;
                alu_b = LIMIT_A;
            end
            S_DBL_RD:
            begin
                alu_a = AW'(base_reg);
                alu_b = AW'(k_reg);
            end
            S_DBL_WR:
            begin
                alu_a = AW'(k_reg);
                alu_b = ONE_A;
            end
            S_DBL_END:
            begin
                alu_a = AW'(base_reg);
                alu_b = AW'(base_reg);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Entry store access, per sequencer step
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = data_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        case (state_reg)
            S_DECODE:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    if (!count_reg[LEVELS])
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_reg[LEVELS-1:0];
                    end
                    else if (rslot_a < CAP_A)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = rslot_a[LEVELS-1:0];
                    end
                end
                else if (cmd_reg == CMD_READ && alu_lt)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_a[LEVELS-1:0];
                end
            end
            S_REM_DEC:
            begin
                mem_rd_en   = 1'b1;                 // fetch the last entry
                mem_rd_addr = alu_sum[LEVELS-1:0];
            end
            S_REM_WR:
            begin
                mem_wr_en   = 1'b1;                 // drop it into the hole
                mem_wr_addr = slot_a[LEVELS-1:0];
                mem_wr_data = mem_rd_data;
            end
            S_DBL_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = k_reg;
            end
            S_DBL_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = dst_reg;
                mem_wr_data = mem_rd_data;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        slot_next   = slot_reg;
        rslot_next  = rslot_reg;
        count_next  = count_reg;
        contr_next  = contr_reg;
        dbl_next    = dbl_reg;
        warn_next   = warn_reg;
        armed_next  = armed_reg;
        en_next     = en_reg;
        placed_next = placed_reg;
        rvalid_next = rvalid_reg;
        err_next    = err_reg;
        base_next   = base_reg;
        k_next      = k_reg;
        dst_next    = dst_reg;

        if (cfg_wr && paddr[2] == REG_DOUBLING_ENABLE)
        begin
            en_next = pwdata[0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd;
                    data_next   = entry_data[ENTRY_WIDTH-1:0];
                    slot_next   = slot_index;
                    rslot_next  = random_slot;
                    placed_next = '0;
                    rvalid_next = 1'b0;
                    err_next    = 1'b0;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!armed_reg && alu_sum >= CUTOFF_A)
                        begin
                            armed_next = 1'b1;
                        end
                        if (!count_reg[LEVELS])
                        begin
                            placed_next = count_a;
                            count_next  = alu_sum[CW-1:0];
                        end
                        else
                        begin
                            // full: contract into a random slot or drop
                            contr_next = contr_inc;
                            if (!warn_reg && contr_inc > WARN_TH)
                            begin
                                warn_next = 1'b1;
                            end
                            placed_next = (rslot_a < CAP_A) ? rslot_a : CAP_A;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else if (alu_lt)
                        begin
                            state_next = S_REM_DEC;
                        end
                        else
                        begin
                            state_next = S_DBL_CHK;
                        end
                    end
                    CMD_READ:
                    begin
                        rvalid_next = alu_lt;
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                        contr_next = '0;
                        dbl_next   = '0;
                        armed_next = 1'b0;
                    end
                    CMD_RESET_SCALE:
                    begin
                        contr_next = '0;
                        dbl_next   = '0;
                        warn_next  = 1'b0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_REM_DEC:
            begin
                count_next = alu_sum[CW-1:0];
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                state_next = S_DBL_CHK;
            end
            S_DBL_CHK:
            begin
                if (!(en_reg && armed_reg) || !alu_lt)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg == '0)
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    base_next  = count_reg[LEVELS-1:0];
                    k_next     = '0;
                    state_next = S_DBL_RD;
                end
            end
            S_DBL_RD:
            begin
                dst_next   = alu_sum[LEVELS-1:0];
                state_next = S_DBL_WR;
            end
            S_DBL_WR:
            begin
                k_next = alu_sum[LEVELS-1:0];
                if (alu_sum == AW'(base_reg))
                begin
                    state_next = S_DBL_END;
                end
                else
                begin
                    state_next = S_DBL_RD;
                end
            end
            S_DBL_END:
            begin
                count_next = alu_sum[CW-1:0];
                dbl_next   = (dbl_reg == 8'hFF) ? dbl_reg : (dbl_reg + 8'd1);
                state_next = S_DBL_CHK;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            contr_reg  <= '0;
            dbl_reg    <= '0;
            warn_reg   <= 1'b0;
            armed_reg  <= 1'b0;
            en_reg     <= 1'b1;
            rvalid_reg <= 1'b0;
            err_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            contr_reg  <= contr_next;
            dbl_reg    <= dbl_next;
            warn_reg   <= warn_next;
            armed_reg  <= armed_next;
            en_reg     <= en_next;
            rvalid_reg <= rvalid_next;
            err_reg    <= err_next;
        end
    end

    // Payload and loop registers: no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        data_reg   <= data_next;
        slot_reg   <= slot_next;
        rslot_reg  <= rslot_next;
        placed_reg <= placed_next;
        base_reg   <= base_next;
        k_reg      <= k_next;
        dst_reg    <= dst_next;
    end

    // Result and status outputs; read data sits in the store's output register
    assign busy                = (state_reg != S_IDLE);
    assign done                = (state_reg == S_DONE);
    assign placed_slot         = placed_reg[10:0];
    assign read_valid          = rvalid_reg;
    assign read_data           = rvalid_reg ? 64'(mem_rd_data) : 64'd0;
    assign entry_count         = count_a[10:0];
    assign contraction_total   = contr_reg;
    assign doubling_total      = dbl_reg;
    assign contraction_warning = warn_reg;
    assign doubling_armed      = armed_reg;
    assign empty_error         = err_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DOUBLING_ENABLE) ? {31'd0, en_reg} : 32'd0;

    // Checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted transaction did not make the block busy");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_a <= CAP_A)
        else $error("entry count above capacity");

    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty_error |-> count_reg == '0 && cmd_reg == CMD_REMOVE)
        else $error("empty doubling error with a non-empty pool");

    a_rvalid_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && read_valid |-> cmd_reg == CMD_READ)
        else $error("read_valid on a non-read transaction");

endmodule : particle_pool_contract_double

`default_nettype wire

[sv/ppcd_alu.sv]
// Shared add/subtract unit with unsigned less-than compare.
`default_nettype none

module ppcd_alu #(
    parameter int AW = 11
) (
    input  wire logic          op,
    input  wire logic [AW-1:0] a,
    input  wire logic [AW-1:0] b,
    output logic      [AW-1:0] sum,
    output logic               lt
);
    import ppcd_pkg::*;

    always_comb
    begin
        sum = (op == ALU_SUB) ? (a - b) : (a + b);
        lt  = (a < b);
    end

endmodule : ppcd_alu

`default_nettype wire

[sv/ppcd_mem.sv]
// Entry store: one write port and one registered read port.
`default_nettype none

module ppcd_mem #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem_reg [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : ppcd_mem

`default_nettype wire

[tb/pool_result_checker.sv]
// Result checker for the sample pool: tracks the pool state, predicts each result, compares.
module pool_result_checker
    import ppcd_pkg::*;
#(
    parameter int LEVELS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  cmd,
    input  logic [63:0] entry_data,
    input  logic [9:0]  slot_index,
    input  logic [10:0] random_slot,
    input  logic        done,
    input  logic [10:0] placed_slot,
    input  logic [63:0] read_data,
    input  logic        read_valid,
    input  logic [10:0] entry_count,
    input  logic [15:0] contraction_total,
    input  logic [7:0]  doubling_total,
    input  logic        contraction_warning,
    input  logic        doubling_armed,
    input  logic        empty_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count
);

    localparam int unsigned CAPACITY        = 1 << LEVELS;
    localparam int unsigned CUTOFF          = 3 * CAPACITY / 4;
    localparam int unsigned SLACK           = (LEVELS > 5) ? (1 << (LEVELS - 5)) : 1;
    localparam int unsigned DOUBLING_LIMIT  = CAPACITY / 2 - SLACK;
    localparam int unsigned CONTRACT_CEIL   = 65535;
    localparam int unsigned DOUBLING_CEIL   = 255;
    localparam int unsigned WARN_PERCENT    = 100;
    localparam int unsigned REPORT_CAP      = 200;
    localparam logic [2:0]  ENABLE_ADDR     = {REG_DOUBLING_ENABLE, 2'b00};

    typedef struct packed {
        logic [10:0] placed_slot;
        logic [63:0] read_data;
        logic        read_valid;
        logic [10:0] entry_count;
        logic [15:0] contraction_total;
        logic [7:0]  doubling_total;
        logic        contraction_warning;
        logic        doubling_armed;
        logic        empty_error;
    } pool_result_t;

    // Shadow copy of the pool
    logic [63:0]  slot_word [CAPACITY];
    int unsigned  level;
    int unsigned  contractions;
    int unsigned  doublings;
    bit           warn;
    bit           armed;
    bit           doubling_on;

    pool_result_t results_due [$];
    pool_result_t want;
    int unsigned  mismatches;

    function automatic pool_result_t predict_pool_result(input logic [2:0] op,
                                                         input logic [63:0] data,
                                                         input logic [9:0] slot,
                                                         input logic [10:0] rslot);
        pool_result_t r;
        int unsigned  c;
        int unsigned  k;
        r = '0;
        case (op)
            CMD_ADD:
            begin
                if (!armed && level + 1 >= CUTOFF)
                    armed = 1'b1;
                if (level < CAPACITY)
                begin
                    slot_word[level] = data;
                    r.placed_slot = 11'(level);
                    level++;
                end
                else
                begin
                    if (contractions < CONTRACT_CEIL)
                        contractions++;
                    if (!warn && contractions * WARN_PERCENT > CAPACITY)
                        warn = 1'b1;
                    if (rslot < CAPACITY)
                    begin
                        slot_word[rslot] = data;
                        r.placed_slot = rslot;
                    end
                    else
                        r.placed_slot = 11'(CAPACITY);
                end
            end
            CMD_REMOVE:
            begin
                if (level != 0)
                begin
                    if (slot < level)
                    begin
                        level--;
                        slot_word[slot] = slot_word[level];
                    end
                    // copy the pool onto itself until it reaches the limit
                    if (doubling_on && armed)
                    begin
                        while (level < DOUBLING_LIMIT && !r.empty_error)
                        begin
                            if (level == 0)
                                r.empty_error = 1'b1;
                            else
                            begin
                                c = level;
                                for (k = 0; k < c && c + k < CAPACITY; k++)
                                    slot_word[c + k] = slot_word[k];
                                level = 2 * c;
                                if (doublings < DOUBLING_CEIL)
                                    doublings++;
                            end
                        end
                    end
                end
            end
            CMD_READ:
            begin
                if (slot < level)
                begin
                    r.read_data  = slot_word[slot];
                    r.read_valid = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                level        = 0;
                contractions = 0;
                doublings    = 0;
                armed        = 1'b0;
            end
            CMD_RESET_SCALE:
            begin
                contractions = 0;
                doublings    = 0;
                warn         = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.entry_count         = 11'(level);
        r.contraction_total   = 16'(contractions);
        r.doubling_total      = 8'(doublings);
        r.contraction_warning = warn;
        r.doubling_armed      = armed;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [63:0] good,
                                        input logic [63:0] seen);
        if (good !== seen)
        begin
            mismatches++;
            // stay quiet past the cap; mismatches are still counted
            if (mismatches <= REPORT_CAP)
                $display("%0t %s: expected %0h, got %0h", $time, field, good, seen);
        end
    endfunction

    // Everything is sampled mid-cycle, where all channel signals are settled
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            level        = 0;
            contractions = 0;
            doublings    = 0;
            warn         = 1'b0;
            armed        = 1'b0;
            doubling_on  = 1'b1;
            mismatches   = 0;
            results_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ENABLE_ADDR)
                doubling_on = pwdata[0];
            if (start && !busy)
                results_due.push_back(predict_pool_result(cmd, entry_data, slot_index,
                                                          random_slot));
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t result with no transaction pending: count %0d",
                                 $time, entry_count);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("placed_slot", want.placed_slot, placed_slot);
                    check_field("read_data", want.read_data, read_data);
                    check_field("read_valid", want.read_valid, read_valid);
                    check_field("entry_count", want.entry_count, entry_count);
                    check_field("contraction_total", want.contraction_total,
                                contraction_total);
                    check_field("doubling_total", want.doubling_total, doubling_total);
                    check_field("contraction_warning", want.contraction_warning,
                                contraction_warning);
                    check_field("doubling_armed", want.doubling_armed, doubling_armed);
                    check_field("empty_error", want.empty_error, empty_error);
                end
            end
        end
        // a transaction still waiting for its result counts as a failure
        fail_count = mismatches + results_due.size();
    end

endmodule

[tb/particle_pool_contract_double_tb.sv]
// Testbench top for the sample pool: stimulus phases, configuration writes and verdict.
module particle_pool_contract_double_tb;
    import ppcd_pkg::*;

    localparam int unsigned CAPACITY        = 1024;
    localparam int unsigned ARM_LEVEL       = 800;
    localparam int unsigned RUN_LIMIT       = 3_000_000;
    localparam int unsigned SATURATING_ADDS = 65_600;
    localparam int unsigned DOUBLING_SWEEPS = 29;
    localparam int unsigned TAIL_CYCLES     = 10;
    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;
    localparam logic [2:0]  ENABLE_ADDR     = {REG_DOUBLING_ENABLE, 2'b00};

    // Every block input starts at a known value
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [2:0]  cmd         = CMD_READ;
    logic [63:0] entry_data  = '0;
    logic [9:0]  slot_index  = '0;
    logic [10:0] random_slot = '0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        busy;
    logic        done;
    logic [10:0] placed_slot;
    logic [63:0] read_data;
    logic        read_valid;
    logic [10:0] entry_count;
    logic [15:0] contraction_total;
    logic [7:0]  doubling_total;
    logic        contraction_warning;
    logic        doubling_armed;
    logic        empty_error;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;

    // Transaction bookkeeping to steer the stimulus, plus the watchdog's cycle count
    int unsigned accepted   = 0;
    int unsigned finished   = 0;
    int unsigned pool_level = 0;
    int unsigned gap_pct    = 0;
    int unsigned cycles     = 0;

    always #2 clk = ~clk;

    particle_pool_contract_double i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cmd                 (cmd),
        .entry_data          (entry_data),
        .slot_index          (slot_index),
        .random_slot         (random_slot),
        .done                (done),
        .placed_slot         (placed_slot),
        .read_data           (read_data),
        .read_valid          (read_valid),
        .entry_count         (entry_count),
        .contraction_total   (contraction_total),
        .doubling_total      (doubling_total),
        .contraction_warning (contraction_warning),
        .doubling_armed      (doubling_armed),
        .empty_error         (empty_error),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    pool_result_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cmd                 (cmd),
        .entry_data          (entry_data),
        .slot_index          (slot_index),
        .random_slot         (random_slot),
        .done                (done),
        .placed_slot         (placed_slot),
        .read_data           (read_data),
        .read_valid          (read_valid),
        .entry_count         (entry_count),
        .contraction_total   (contraction_total),
        .doubling_total      (doubling_total),
        .contraction_warning (contraction_warning),
        .doubling_armed      (doubling_armed),
        .empty_error         (empty_error),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .pready              (pready),
        .fail_count          (fail_count)
    );

    // Latch the pool size reported by each result; the stimulus steers on it
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            pool_level = entry_count;
            finished++;
        end
    end

    // Watchdog: a hung handshake or a runaway pool ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == RUN_LIMIT)
        begin
            $display("particle_pool_contract_double_tb failed");
            $finish;
        end
    end

    function automatic logic [63:0] entry_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly a live slot, sometimes anywhere in the index range
    function automatic logic [9:0] pick_slot(input int unsigned level);
        if (level != 0 && $urandom_range(7) != 0)
            return 10'($urandom_range(level - 1));
        return 10'($urandom_range(CAPACITY - 1));
    endfunction

    // A quarter of the time ask for the new entry to be dropped when full
    function automatic logic [10:0] pick_replacement();
        if ($urandom_range(3) == 0)
            return 11'(CAPACITY);
        return 11'($urandom_range(CAPACITY - 1));
    endfunction

    // Offer one transaction: idle first at the phase's rate, then hold start
    // until busy is low mid-cycle; the following rising edge takes it.
    task automatic send(input logic [2:0] op, input logic [63:0] data,
                        input logic [9:0] slot, input logic [10:0] rslot);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= op;
        entry_data  <= data;
        slot_index  <= slot;
        random_slot <= rslot;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        accepted++;
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (finished != accepted);
    endtask

    // APB write of doubling_enable; upper data bits carry noise
    task automatic write_enable(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENABLE_ADDR;
        pwdata  <= {31'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Add until the pool holds at least target entries, with reads mixed in
    task automatic fill_to(input int unsigned target, input int unsigned read_pct);
        while (pool_level < target)
        begin
            while (pool_level + (accepted - finished) < target)
            begin
                if ($urandom_range(99) < read_pct)
                    send(CMD_READ, entry_word(), pick_slot(pool_level), pick_replacement());
                else
                    send(CMD_ADD, entry_word(), pick_slot(pool_level), pick_replacement());
            end
            drain();
        end
    endtask

    // Remove live entries down to target; doubling must be off or disarmed
    task automatic walk_down(input int unsigned target, input int unsigned read_pct);
        int unsigned est;
        while (pool_level > target)
        begin
            est = pool_level - (accepted - finished);
            while (est > target && est <= CAPACITY)
            begin
                if ($urandom_range(99) < read_pct)
                    send(CMD_READ, entry_word(), pick_slot(est), pick_replacement());
                else
                    send(CMD_REMOVE, entry_word(), 10'($urandom_range(est - 1)),
                         pick_replacement());
                est = pool_level - (accepted - finished);
            end
            drain();
        end
    endtask

    // Random mix of commands; clear is left to the scenario itself
    task automatic churn(input int unsigned n, input int unsigned add_pct,
                         input int unsigned remove_pct);
        int unsigned roll;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < add_pct)
                send(CMD_ADD, entry_word(), pick_slot(pool_level), pick_replacement());
            else if (roll < add_pct + remove_pct)
                send(CMD_REMOVE, entry_word(), pick_slot(pool_level), pick_replacement());
            else if (roll < 97)
                send(CMD_READ, entry_word(), pick_slot(pool_level), pick_replacement());
            else if (roll < 99)
                send(CMD_RESET_SCALE, entry_word(), pick_slot(pool_level),
                     pick_replacement());
            else
                send(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), entry_word(),
                     pick_slot(pool_level), pick_replacement());
        end
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, back to back
        gap_pct = 0;
        write_enable(1'b1);
        send(CMD_READ, '1, 10'd0, 11'd0);              // read of an empty pool
        send(CMD_REMOVE, '0, 10'd0, 11'd0);            // remove on empty: ignored
        send(CMD_ADD, '1, 10'd1023, 11'(CAPACITY));
        send(CMD_ADD, '0, 10'd0, 11'd0);
        send(CMD_ADD, 64'h8000_0000_0000_0001, 10'd0, 11'd1023);
        send(CMD_ADD, 64'h0123_4567_89ab_cdef, 10'd512, 11'd1);
        send(CMD_READ, '0, 10'd0, 11'd0);
        send(CMD_READ, '0, 10'd3, 11'd0);
        send(CMD_READ, '0, 10'd4, 11'd0);              // one past the last entry
        send(CMD_READ, '0, 10'd1023, 11'(CAPACITY));
        send(CMD_REMOVE, '1, 10'd1023, 11'd0);         // slot beyond count: nothing moves
        send(CMD_REMOVE, '0, 10'd1, 11'd0);            // last entry fills the hole
        send(CMD_READ, '0, 10'd1, 11'd0);
        for (int op = CMD_SPARE_FIRST; op <= CMD_SPARE_LAST; op++)
            send(3'(op), '1, 10'd1023, 11'(CAPACITY));
        send(CMD_RESET_SCALE, '0, 10'd0, 11'd0);
        send(CMD_CLEAR, '0, 10'd0, 11'd0);
        send(CMD_READ, '0, 10'd0, 11'd0);              // stale slot after clear
        send(CMD_ADD, 64'haaaa_aaaa_aaaa_aaaa, 10'd0, 11'd0);
        send(CMD_REMOVE, '0, 10'd0, 11'd0);            // back to empty, not armed
        drain();

        // Grow the pool to full with the sender idling about half the time;
        // crossing the cutoff arms doubling, then force contractions at full.
        gap_pct = 54;
        churn(150, 60, 25);
        fill_to(CAPACITY, 15);
        churn(80, 75, 0);
        drain();

        // Shrink with doubling enabled; dropping below the limit copies the pool
        gap_pct = 36;
        send(CMD_RESET_SCALE, entry_word(), pick_slot(pool_level), pick_replacement());
        churn(800, 5, 85);
        drain();

        // Armed but disabled: walk down to one entry, enable, then remove the
        // last entry so doubling meets an empty pool.
        write_enable(1'b0);
        gap_pct = 0;
        walk_down(1, 10);
        write_enable(1'b1);
        send(CMD_REMOVE, entry_word(), 10'd0, pick_replacement());
        send(CMD_REMOVE, entry_word(), 10'd0, pick_replacement());   // empty: ignored
        repeat (3)
            send(CMD_ADD, entry_word(), pick_slot(0), pick_replacement());
        // slot beyond count, so only the doubling runs: many rounds from three
        send(CMD_REMOVE, entry_word(), 10'd1023, pick_replacement());
        gap_pct = 54;
        churn(200, 30, 40);
        drain();
        send(CMD_CLEAR, entry_word(), pick_slot(pool_level), pick_replacement());
        send(CMD_RESET_SCALE, entry_word(), pick_slot(pool_level), pick_replacement());
        drain();

        // Drive the contraction counter into saturation on a full pool
        gap_pct = 0;
        fill_to(CAPACITY, 0);
        repeat (SATURATING_ADDS)
            send(CMD_ADD, entry_word(), pick_slot(pool_level), pick_replacement());
        repeat (8)
            send(CMD_READ, entry_word(), pick_slot(pool_level), pick_replacement());
        // clear keeps the warning flag set above
        send(CMD_CLEAR, entry_word(), pick_slot(pool_level), pick_replacement());
        drain();

        // Saturate the doubling counter: each sweep walks down to one entry
        // with doubling off, then lets a single remove double it nine times.
        fill_to(ARM_LEVEL, 0);
        for (int sweep = 0; sweep < DOUBLING_SWEEPS; sweep++)
        begin
            gap_pct = (sweep % 4 == 0) ? 36 : 0;
            write_enable(1'b0);
            walk_down(1, 0);
            write_enable(1'b1);
            send(CMD_REMOVE, entry_word(), 10'($urandom_range(CAPACITY - 1, 1)),
                 pick_replacement());
            drain();
        end

        // Random tail, then drop the scaling counters once more
        gap_pct = 54;
        churn(120, 40, 30);
        send(CMD_RESET_SCALE, entry_word(), pick_slot(pool_level), pick_replacement());
        drain();

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("particle_pool_contract_double_tb passed");
        else
            $display("particle_pool_contract_double_tb failed");
        $finish;
    end

endmodule

[filelist.f]
sv/ppcd_pkg.sv
sv/ppcd_alu.sv
sv/ppcd_mem.sv
sv/particle_pool_contract_double.sv
tb/pool_result_checker.sv
tb/particle_pool_contract_double_tb.sv
